>>> design/mrbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrbp_pkg
// Command and configuration register codes shared by the rectangle packer.
// ----------------------------------------------------------------------------
package mrbp_pkg;

    // Command codes carried by one input item.
    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_BIN_WIDTH  = 1'b0;
    localparam logic CFG_BIN_HEIGHT = 1'b1;

    // Reset value of both bin size registers, in pixels.
    localparam int BIN_RESET = 1024;

endpackage
`default_nettype wire

>>> design/mrbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mrbp_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire  [$clog2(DEPTH)-1:0]        i_waddr,
    input  wire  [WIDTH-1:0]                i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> design/maxrects_bin_packer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maxrects_bin_packer_top
// MaxRects rectangle packer with best short-side fit over a free list in RAM.
// ----------------------------------------------------------------------------
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+---------------------
//  command  | i_cmd, i_rect_width, i_rect_height             | start high, busy low
//  result   | o_placed, o_pos_x, o_pos_y, o_list_overflow    | o_valid, one cycle
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata               | i_cfg_we, no wait
//
// A clear item is answered without leaving idle. A place item first scans the
// free list, reading and scoring one entry at a time, then splits it: each free
// entry is read, latched and tested for overlap, and each non-empty piece is
// pruned against the list being rebuilt one entry at a time, since the single
// read port of the rebuild RAM is the bottleneck. Reset is synchronous and
// leaves the single full-bin free rectangle; no clearing pass is needed. Results
// cannot be stalled; on a place item busy stays high until the result cycle.
// ----------------------------------------------------------------------------
module maxrects_bin_packer_top
    import mrbp_pkg::*;
#(
    parameter int MAX_FREE   = 64,
    parameter int COORD_BITS = 13
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire                   i_cmd,
    input  wire  [COORD_BITS-1:0] i_rect_width,
    input  wire  [COORD_BITS-1:0] i_rect_height,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_idx,
    input  wire  [COORD_BITS-1:0] i_cfg_wdata,
    output logic                  o_valid,
    output logic                  o_placed,
    output logic [COORD_BITS-1:0] o_pos_x,
    output logic [COORD_BITS-1:0] o_pos_y,
    output logic                  o_list_overflow
);

    localparam int CW   = COORD_BITS;
    localparam int SW   = COORD_BITS + 1;
    localparam int AW   = $clog2(MAX_FREE);
    localparam int CNTW = $clog2(MAX_FREE + 1);
    localparam int BW   = 4 * COORD_BITS;
    localparam logic [CW-1:0]   BinReset = CW'(BIN_RESET);
    localparam logic [CNTW-1:0] MaxCount = CNTW'(MAX_FREE);
    localparam logic [CNTW-1:0] CountOne = CNTW'(1);

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
    } t_box;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRCH_RD, ST_SRCH_EV, ST_DECIDE, ST_SP_RD, ST_SP_EV, ST_SP_OV,
        ST_PC, ST_PR_RD, ST_PR_EV, ST_PUSH, ST_NXT_J, ST_NXT_I, ST_FIN
    } t_state;

    // Outer fully covers inner.
    function automatic logic covers(input t_box o, input t_box n);
        logic [SW-1:0] o_r, o_b, n_r, n_b;
        o_r = SW'(o.x) + SW'(o.w);
        o_b = SW'(o.y) + SW'(o.h);
        n_r = SW'(n.x) + SW'(n.w);
        n_b = SW'(n.y) + SW'(n.h);
        return (n.x >= o.x) && (n.y >= o.y) && (n_r <= o_r) && (n_b <= o_b);
    endfunction

    t_state          r_state;
    logic [CW-1:0]   r_bin_w, r_bin_h;
    logic            r_fresh;
    logic [CW-1:0]   r_fresh_w, r_fresh_h;
    logic            r_bank;
    logic [CNTW-1:0] r_count;
    logic            r_ovf;
    logic [CW-1:0]   r_rw, r_rh;
    logic [CNTW-1:0] r_fi;
    logic            r_found, r_exact;
    logic [CW-1:0]   r_best, r_px, r_py;
    logic [CNTW-1:0] r_rc, r_rk, r_wp;
    t_box            r_f;
    logic [1:0]      r_j;
    logic            r_drop;

    logic [BW-1:0]   a_rdata, b_rdata;
    t_box            free_rd, reb_rd;
    logic [AW-1:0]   fi_addr, rk_addr;
    logic            we;
    logic [AW-1:0]   waddr;
    t_box            wdata;

    // Current free list read: the freshly cleared list is the bin itself.
    always_comb begin
        if (r_fresh) begin
            free_rd = '{x: '0, y: '0, w: r_fresh_w, h: r_fresh_h};
        end else begin
            free_rd = r_bank ? t_box'(b_rdata) : t_box'(a_rdata);
        end
        reb_rd = r_bank ? t_box'(a_rdata) : t_box'(b_rdata);
    end

    assign fi_addr = r_fi[AW-1:0];
    assign rk_addr = r_rk[AW-1:0];

    // Geometry of the latched free entry against the placed rectangle.
    logic [SW-1:0] fx, fy, fr, fb, rx, ry, rr, rb, ix, iy, ir, ib;
    logic          overlap;
    t_box          piece;
    logic          piece_empty;

    always_comb begin
        fx = SW'(r_f.x);
        fy = SW'(r_f.y);
        fr = SW'(r_f.x) + SW'(r_f.w);
        fb = SW'(r_f.y) + SW'(r_f.h);
        rx = SW'(r_px);
        ry = SW'(r_py);
        rr = SW'(r_px) + SW'(r_rw);
        rb = SW'(r_py) + SW'(r_rh);
        ix = (fx > rx) ? fx : rx;
        iy = (fy > ry) ? fy : ry;
        ir = (fr < rr) ? fr : rr;
        ib = (fb < rb) ? fb : rb;
        overlap = (ir > ix) && (ib > iy);
        case (r_j)
            2'd0: piece = '{x: r_f.x, y: r_f.y, w: CW'(ix - fx), h: r_f.h};
            2'd1: piece = '{x: CW'(ir), y: r_f.y, w: CW'(fr - ir), h: r_f.h};
            2'd2: piece = '{x: r_f.x, y: r_f.y, w: r_f.w, h: CW'(iy - fy)};
            default: piece = '{x: r_f.x, y: CW'(ib), w: r_f.w, h: CW'(fb - ib)};
        endcase
        piece_empty = (piece.w == '0) || (piece.h == '0);
    end

    // Single write port into the rebuild list.
    always_comb begin
        we    = 1'b0;
        waddr = r_rc[AW-1:0];
        wdata = r_f;
        case (r_state)
            ST_SP_OV: begin
                we    = !overlap && (r_rc < MaxCount);
                waddr = r_rc[AW-1:0];
                wdata = r_f;
            end
            ST_PR_EV: begin
                we    = r_drop || !covers(piece, reb_rd);
                waddr = r_wp[AW-1:0];
                wdata = reb_rd;
            end
            ST_PUSH: begin
                we    = !r_drop && (r_wp < MaxCount);
                waddr = r_wp[AW-1:0];
                wdata = piece;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Bank 0 means RAM A holds the free list and RAM B the list being rebuilt.
    mrbp_ram #(.WIDTH(BW), .DEPTH(MAX_FREE)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we && r_bank),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_bank ? rk_addr : fi_addr),
        .o_rdata (a_rdata)
    );

    mrbp_ram #(.WIDTH(BW), .DEPTH(MAX_FREE)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we && !r_bank),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_bank ? fi_addr : rk_addr),
        .o_rdata (b_rdata)
    );

    assign busy = (r_state != ST_IDLE);

    // Search evaluation of the entry just read.
    logic          fits;
    logic [CW-1:0] dw, dh, mleft;
    always_comb begin
        fits  = (free_rd.w >= r_rw) && (free_rd.h >= r_rh);
        dw    = free_rd.w - r_rw;
        dh    = free_rd.h - r_rh;
        mleft = (dw < dh) ? dw : dh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_bin_w         <= BinReset;
            r_bin_h         <= BinReset;
            r_fresh         <= 1'b1;
            r_fresh_w       <= BinReset;
            r_fresh_h       <= BinReset;
            r_bank          <= 1'b0;
            r_count         <= CountOne;
            r_ovf           <= 1'b0;
            o_valid         <= 1'b0;
            o_placed        <= 1'b0;
            o_pos_x         <= '0;
            o_pos_y         <= '0;
            o_list_overflow <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BIN_WIDTH) begin
                    r_bin_w <= i_cfg_wdata;
                end else begin
                    r_bin_h <= i_cfg_wdata;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_rw    <= i_rect_width;
                        r_rh    <= i_rect_height;
                        r_fi    <= '0;
                        r_found <= 1'b0;
                        r_exact <= 1'b0;
                        r_best  <= '0;
                        r_px    <= '0;
                        r_py    <= '0;
                        if (i_cmd == CMD_CLEAR) begin
                            r_fresh         <= 1'b1;
                            r_fresh_w       <= r_bin_w;
                            r_fresh_h       <= r_bin_h;
                            r_count         <= CountOne;
                            r_ovf           <= 1'b0;
                            o_valid         <= 1'b1;
                            o_placed        <= 1'b0;
                            o_pos_x         <= '0;
                            o_pos_y         <= '0;
                            o_list_overflow <= 1'b0;
                        end else if (r_count == '0) begin
                            r_state <= ST_DECIDE;
                        end else begin
                            r_state <= ST_SRCH_RD;
                        end
                    end
                end
                ST_SRCH_RD: begin
                    r_state <= ST_SRCH_EV;
                end
                ST_SRCH_EV: begin
                    if (fits && mleft == '0) begin
                        r_exact <= 1'b1;
                        r_px    <= free_rd.x;
                        r_py    <= free_rd.y;
                        r_state <= ST_DECIDE;
                    end else begin
                        if (fits && (!r_found || mleft < r_best)) begin
                            r_found <= 1'b1;
                            r_best  <= mleft;
                            r_px    <= free_rd.x;
                            r_py    <= free_rd.y;
                        end
                        if (r_fi + CountOne == r_count) begin
                            r_state <= ST_DECIDE;
                        end else begin
                            r_fi    <= r_fi + CountOne;
                            r_state <= ST_SRCH_RD;
                        end
                    end
                end
                ST_DECIDE: begin
                    if ((r_exact || (r_found && r_best <= r_bin_w && r_best <= r_bin_h))
                        && r_rw != '0 && r_rh != '0) begin
                        r_rc    <= '0;
                        r_fi    <= '0;
                        r_state <= ST_SP_RD;
                    end else begin
                        o_valid         <= 1'b1;
                        o_placed        <= 1'b0;
                        o_pos_x         <= '0;
                        o_pos_y         <= '0;
                        o_list_overflow <= r_ovf;
                        r_state         <= ST_IDLE;
                    end
                end
                ST_SP_RD: begin
                    r_state <= ST_SP_EV;
                end
                ST_SP_EV: begin
                    r_f     <= free_rd;
                    r_state <= ST_SP_OV;
                end
                ST_SP_OV: begin
                    if (!overlap) begin
                        if (r_rc < MaxCount) begin
                            r_rc <= r_rc + CountOne;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= ST_NXT_I;
                    end else begin
                        r_j     <= 2'd0;
                        r_state <= ST_PC;
                    end
                end
                ST_PC: begin
                    if (piece_empty) begin
                        r_state <= ST_NXT_J;
                    end else begin
                        r_rk   <= '0;
                        r_wp   <= '0;
                        r_drop <= 1'b0;
                        r_state <= (r_rc == '0) ? ST_PUSH : ST_PR_RD;
                    end
                end
                ST_PR_RD: begin
                    r_state <= ST_PR_EV;
                end
                ST_PR_EV: begin
                    // A rebuilt entry the piece covers is removed; the rest shift down.
                    if (r_drop || !covers(piece, reb_rd)) begin
                        if (!r_drop && covers(reb_rd, piece)) begin
                            r_drop <= 1'b1;
                        end
                        r_wp <= r_wp + CountOne;
                    end
                    if (r_rk + CountOne == r_rc) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_rk    <= r_rk + CountOne;
                        r_state <= ST_PR_RD;
                    end
                end
                ST_PUSH: begin
                    if (!r_drop && r_wp < MaxCount) begin
                        r_rc <= r_wp + CountOne;
                    end else begin
                        r_rc <= r_wp;
                        if (!r_drop) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    r_state <= ST_NXT_J;
                end
                ST_NXT_J: begin
                    if (r_j == 2'd3) begin
                        r_state <= ST_NXT_I;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= ST_PC;
                    end
                end
                ST_NXT_I: begin
                    if (r_fi + CountOne == r_count) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_fi    <= r_fi + CountOne;
                        r_state <= ST_SP_RD;
                    end
                end
                ST_FIN: begin
                    // The rebuilt list becomes the free list by swapping banks.
                    r_bank          <= !r_bank;
                    r_fresh         <= 1'b0;
                    r_count         <= r_rc;
                    o_valid         <= 1'b1;
                    o_placed        <= 1'b1;
                    o_pos_x         <= r_px;
                    o_pos_y         <= r_py;
                    o_list_overflow <= r_ovf;
                    r_state         <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rectangle packer. A queue of commands, bin size
// writes and idle points feeds a clocked driver. A local copy of the free-list
// algorithm predicts each result, and a clocked monitor compares the results.
// ----------------------------------------------------------------------------
module testbench;
    import mrbp_pkg::*;

    localparam int NFREE    = 64;
    localparam int CB       = 13;
    localparam int WATCHDOG = 400000;

    typedef enum logic [1:0] {
        Q_ITEM,
        Q_CFG,
        Q_SYNC
    } qkind_t;

    typedef struct {
        qkind_t          kind;
        logic            cmd;
        logic [CB-1:0]   a;
        logic [CB-1:0]   b;
    } pend_t;

    typedef struct {
        logic            placed;
        logic [CB-1:0]   x;
        logic [CB-1:0]   y;
        logic            ovf;
    } placement_t;

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } box_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          i_cmd = CMD_PLACE;
    logic [CB-1:0] i_rect_width = '0;
    logic [CB-1:0] i_rect_height = '0;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_idx = CFG_BIN_WIDTH;
    logic [CB-1:0] i_cfg_wdata = '0;
    wire           busy;
    wire           o_valid;
    wire           o_placed;
    wire  [CB-1:0] o_pos_x;
    wire  [CB-1:0] o_pos_y;
    wire           o_list_overflow;

    maxrects_bin_packer_top #(
        .MAX_FREE  (NFREE),
        .COORD_BITS(CB)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_placed       (o_placed),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_list_overflow(o_list_overflow)
    );

    always #2 i_clk = ~i_clk;

    pend_t      pending[$];
    placement_t placements_due[$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         stim_done = 0;
    bit         calm = 0;

    // Shadow of the packer: bin size registers, free list and overflow flag.
    int   bin_w = BIN_RESET;
    int   bin_h = BIN_RESET;
    box_t free_boxes[NFREE];
    box_t fresh_boxes[NFREE];
    int   free_n = 1;
    int   fresh_n = 0;
    bit   spill = 0;

    function automatic bit covers(box_t o, box_t i);
        return i.x >= o.x && i.y >= o.y && i.x + i.w <= o.x + o.w &&
               i.y + i.h <= o.y + o.h;
    endfunction

    function automatic void fresh_push(box_t b);
        if (fresh_n < NFREE) begin
            fresh_boxes[fresh_n] = b;
            fresh_n++;
        end else begin
            spill = 1;
        end
    endfunction

    // Prune a new piece against the list being rebuilt, then append it unless an entry covers it.
    function automatic void fresh_add(box_t p);
        int k;
        k = 0;
        while (k < fresh_n) begin
            if (covers(p, fresh_boxes[k])) begin
                for (int m = k; m < fresh_n - 1; m++) fresh_boxes[m] = fresh_boxes[m + 1];
                fresh_n--;
            end else if (covers(fresh_boxes[k], p)) begin
                return;
            end else begin
                k++;
            end
        end
        fresh_push(p);
    endfunction

    function automatic void split_around(box_t r);
        box_t f;
        box_t pc[4];
        int   ix, iy, ir, ib, fr, fb;
        fresh_n = 0;
        for (int i = 0; i < free_n; i++) begin
            f  = free_boxes[i];
            ix = f.x > r.x ? f.x : r.x;
            iy = f.y > r.y ? f.y : r.y;
            fr = f.x + f.w;
            fb = f.y + f.h;
            ir = fr < r.x + r.w ? fr : r.x + r.w;
            ib = fb < r.y + r.h ? fb : r.y + r.h;
            if (ir - ix <= 0 || ib - iy <= 0) begin
                fresh_push(f);
                continue;
            end
            pc[0] = '{f.x, f.y, ix - f.x, f.h};
            pc[1] = '{ir, f.y, fr - ir, f.h};
            pc[2] = '{f.x, f.y, f.w, iy - f.y};
            pc[3] = '{f.x, ib, f.w, fb - ib};
            for (int j = 0; j < 4; j++)
                if (pc[j].w > 0 && pc[j].h > 0) fresh_add(pc[j]);
        end
        for (int i = 0; i < fresh_n; i++) free_boxes[i] = fresh_boxes[i];
        free_n = fresh_n;
    endfunction

    function automatic void empty_bin();
        free_boxes[0] = '{0, 0, bin_w, bin_h};
        free_n = 1;
        spill = 0;
    endfunction

    // Best short-side fit: first exact fit wins, else first smallest leftover.
    function automatic placement_t pack_one(logic cmd, int rw, int rh);
        placement_t res;
        bit found, exact, ok;
        int best, px, py, dw, dh, m;
        res = '{1'b0, '0, '0, 1'b0};
        if (cmd == CMD_CLEAR) begin
            empty_bin();
            return res;
        end
        found = 0; exact = 0; best = 0; px = 0; py = 0;
        for (int i = 0; i < free_n; i++) begin
            if (free_boxes[i].w >= rw && free_boxes[i].h >= rh) begin
                dw = free_boxes[i].w - rw;
                dh = free_boxes[i].h - rh;
                m  = dw < dh ? dw : dh;
                if (m <= 0) begin
                    exact = 1;
                    px = free_boxes[i].x;
                    py = free_boxes[i].y;
                    break;
                end
                if (!found || m < best) begin
                    found = 1;
                    best = m;
                    px = free_boxes[i].x;
                    py = free_boxes[i].y;
                end
            end
        end
        ok = exact || (found && best <= bin_w && best <= bin_h);
        if (ok && rw > 0 && rh > 0) begin
            split_around('{px, py, rw, rh});
            res.placed = 1'b1;
            res.x = px[CB-1:0];
            res.y = py[CB-1:0];
        end
        res.ovf = spill;
        return res;
    endfunction

    function automatic int draw_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: one nonblocking assignment per signal per edge, from locals.
    int gap = 0;
    int settle = 0;
    always @(posedge i_clk) begin
        logic          n_start, n_cmd, n_we, n_idx;
        logic [CB-1:0] n_a, n_b, n_wd;
        bit            free_slot;
        pend_t         hd;
        placement_t    pred;
        n_start = start; n_cmd = i_cmd; n_a = i_rect_width; n_b = i_rect_height;
        n_we = 1'b0; n_idx = i_cfg_idx; n_wd = i_cfg_wdata;
        if (i_rst_n) begin
            free_slot = !start;
            if (start && !busy) begin
                pred = pack_one(i_cmd, i_rect_width, i_rect_height);
                placements_due = {placements_due, pred};
                idle_cycles = 0;
                free_slot = 1;
            end
            if (free_slot) begin
                n_start = 1'b0;
                if (gap > 0) begin
                    gap--;
                end else if (pending.size() != 0) begin
                    hd = pending[0];
                    case (hd.kind)
                        Q_ITEM: begin
                            n_start = 1'b1;
                            n_cmd = hd.cmd;
                            n_a = hd.a;
                            n_b = hd.b;
                            void'(pending.pop_front());
                            gap = draw_gap();
                        end
                        Q_SYNC: begin
                            // Every item yields one result, so an empty result queue held while
                            // busy and start stay low means the block is idle.
                            if (placements_due.size() == 0 && !busy && !start) begin
                                settle++;
                                if (settle >= 8) begin
                                    settle = 0;
                                    void'(pending.pop_front());
                                end
                            end else begin
                                settle = 0;
                            end
                        end
                        default: begin
                            n_we = 1'b1;
                            n_idx = hd.cmd;
                            n_wd = hd.a;
                            if (hd.cmd == CFG_BIN_WIDTH) bin_w = hd.a;
                            else bin_h = hd.a;
                            void'(pending.pop_front());
                        end
                    endcase
                end
            end
        end
        start <= n_start;
        i_cmd <= n_cmd;
        i_rect_width <= n_a;
        i_rect_height <= n_b;
        i_cfg_we <= n_we;
        i_cfg_idx <= n_idx;
        i_cfg_wdata <= n_wd;
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        placement_t want;
        if (i_rst_n) begin
            idle_cycles++;
            if (o_valid) begin
                idle_cycles = 0;
                if (placements_due.size() == 0) begin
                    $display("%0t: unexpected result placed=%0b x=%0d y=%0d ovf=%0b",
                             $time, o_placed, o_pos_x, o_pos_y, o_list_overflow);
                    errors++;
                end else begin
                    want = placements_due.pop_front();
                    if (o_placed !== want.placed) begin
                        $display("%0t: placed expected %0b actual %0b", $time,
                                 want.placed, o_placed);
                        errors++;
                    end
                    if (o_pos_x !== want.x) begin
                        $display("%0t: pos_x expected %0d actual %0d", $time, want.x, o_pos_x);
                        errors++;
                    end
                    if (o_pos_y !== want.y) begin
                        $display("%0t: pos_y expected %0d actual %0d", $time, want.y, o_pos_y);
                        errors++;
                    end
                    if (o_list_overflow !== want.ovf) begin
                        $display("%0t: list_overflow expected %0b actual %0b", $time,
                                 want.ovf, o_list_overflow);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic put_item(logic cmd, int a, int b);
        pend_t p;
        p = '{Q_ITEM, cmd, a[CB-1:0], b[CB-1:0]};
        pending = {pending, p};
    endtask

    task automatic put_bin(int w, int h);
        pend_t p;
        p = '{Q_SYNC, 1'b0, '0, '0};
        pending = {pending, p};
        p = '{Q_CFG, CFG_BIN_WIDTH, w[CB-1:0], '0};
        pending = {pending, p};
        p = '{Q_CFG, CFG_BIN_HEIGHT, h[CB-1:0], '0};
        pending = {pending, p};
    endtask

    // Mostly sizes that fit a few times; now and then zero, oversize or odd.
    function automatic int pick_size(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (r < 10) return $urandom_range(0, 4096);
        if (r < 15) return lim;
        return $urandom_range(1, lim / 3 + 1);
    endfunction

    initial begin
        int w, h, n;
        int sizes[6][2];
        sizes = '{'{1, 1}, '{4096, 4096}, '{1024, 1024}, '{4096, 1},
                  '{64, 300}, '{1, 4096}};
        for (int i = 0; i < NFREE; i++) begin
            free_boxes[i] = '{0, 0, 0, 0};
            fresh_boxes[i] = '{0, 0, 0, 0};
        end
        empty_bin();

        // Directed part on the reset bin of 1024 by 1024.
        put_item(CMD_PLACE, 0, 0);
        put_item(CMD_PLACE, 0, 100);
        put_item(CMD_PLACE, 100, 0);
        put_item(CMD_PLACE, 4096, 4096);
        put_item(CMD_PLACE, 1024, 1024);
        put_item(CMD_PLACE, 1, 1);
        put_item(CMD_CLEAR, 0, 0);
        put_item(CMD_PLACE, 1024, 10);
        put_item(CMD_PLACE, 300, 500);
        put_item(CMD_PLACE, 724, 1014);
        put_item(CMD_PLACE, 300, 514);
        put_item(CMD_PLACE, 1, 1);
        put_item(CMD_CLEAR, 8191, 8191);
        // Sizes change only at the next clear, so place once before it.
        put_bin(1, 1);
        put_item(CMD_PLACE, 1, 1);
        put_item(CMD_CLEAR, 0, 0);
        put_item(CMD_PLACE, 1, 1);
        put_item(CMD_PLACE, 1, 1);
        put_item(CMD_CLEAR, 0, 0);
        put_item(CMD_PLACE, 2, 1);
        put_bin(4096, 4096);
        put_item(CMD_CLEAR, 0, 0);
        put_item(CMD_PLACE, 4096, 4096);
        put_item(CMD_CLEAR, 0, 0);
        put_item(CMD_PLACE, 4095, 2049);
        put_item(CMD_PLACE, 1, 2047);

        // Random part: phases of bin sizes with runs of placements.
        n = 0;
        for (int ph = 0; n < 580; ph++) begin
            if (ph < 6) begin
                w = sizes[ph][0];
                h = sizes[ph][1];
            end else begin
                w = $urandom_range(1, 4096);
                h = $urandom_range(1, 4096);
            end
            put_bin(w, h);
            put_item(CMD_CLEAR, $urandom_range(0, 4096), $urandom_range(0, 4096));
            n++;
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(0, 99) < 6) put_item(CMD_CLEAR, 0, 0);
                else put_item(CMD_PLACE, pick_size(w), pick_size(h));
                n++;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                // Toggle between randomly gapped and back-to-back stretches.
                while (!stim_done) begin
                    repeat ($urandom_range(200, 3000)) @(posedge i_clk);
                    calm = !calm;
                end
            end
            begin
                wait (pending.size() == 0);
                @(posedge i_clk);
                while (start || placements_due.size() != 0) @(posedge i_clk);
                repeat (50) @(posedge i_clk);
                stim_done = 1;
            end
        join
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
design/mrbp_pkg.sv
design/mrbp_ram.sv
design/maxrects_bin_packer_top.sv
verif/testbench.sv
